>>> design/djs_pkg.sv
package djs_pkg;

    localparam int DefaultMaxSlots = 32;

    localparam int IdW     = 10;
    localparam int DlW     = 6;
    localparam int ProfitW = 16;
    localparam int SlotW   = 6;
    localparam int SumW    = 21;
    localparam int CountW  = 6;

    localparam logic KindDecision = 1'b0;
    localparam logic KindListing  = 1'b1;

    typedef struct packed {
        logic [IdW-1:0]     job_id;
        logic [DlW-1:0]     deadline;
        logic [ProfitW-1:0] profit;
        logic               first_job;
        logic               last_job;
    } t_job;

    typedef struct packed {
        logic               kind;
        logic               accepted;
        logic [SlotW-1:0]   slot_index;
        logic [IdW-1:0]     job_id_out;
        logic [ProfitW-1:0] profit_out;
        logic [SumW-1:0]    total_profit;
        logic [CountW-1:0]  job_count;
        logic               last_out;
    } t_result;

    typedef struct packed {
        logic load;
        logic decide;
        logic list;
    } t_cmd;

    typedef struct packed {
        logic more_list;
        logic list_end;
    } t_status;

endpackage

>>> design/djs_job_if.sv
interface djs_job_if import djs_pkg::*; ();
    logic valid;
    logic ready;
    t_job data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/djs_result_if.sv
interface djs_result_if import djs_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/djs_ctrl.sv
module djs_ctrl import djs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LIST
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == ST_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.decide = (r_state == ST_EVAL) && out_free;
        o_cmd.list   = (r_state == ST_LIST) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.decide || o_cmd.list) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (out_free) begin
                        r_state <= i_status.more_list ? ST_LIST : ST_IDLE;
                    end
                end
                ST_LIST: begin
                    if (out_free) begin
                        if (i_status.list_end) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/djs_datapath.sv
module djs_datapath import djs_pkg::*; #(
    parameter int MAX_SLOTS = DefaultMaxSlots
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_job    i_job,
    output t_status o_status,
    output t_result o_result
);

    localparam int CntW = $clog2(MAX_SLOTS + 1);
    localparam int IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    // slot cells
    logic [IdW-1:0]     r_cell_id     [MAX_SLOTS];
    logic [DlW-1:0]     r_cell_dl     [MAX_SLOTS];
    logic [ProfitW-1:0] r_cell_profit [MAX_SLOTS];

    logic [CntW-1:0]    r_count;
    logic [SumW-1:0]    r_sum;
    logic [IdxW-1:0]    r_list_idx;

    logic [IdW-1:0]     r_id;
    logic [DlW-1:0]     r_dl;
    logic [ProfitW-1:0] r_profit;
    logic               r_last;

    t_result            r_out;

    logic [MAX_SLOTS-1:0] le;
    logic [MAX_SLOTS-1:0] at_pos;
    logic [MAX_SLOTS-1:0] late;
    logic [CntW-1:0]      pos;
    logic                 ok;
    logic [CntW-1:0]      n_count;
    logic [SumW:0]        sum_wide;
    logic [SumW-1:0]      n_sum;
    logic [CntW-1:0]      list_next;

    always_comb begin
        pos = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            le[i] = (CntW'(i) < r_count) && (r_cell_dl[i] <= r_dl);
        end
        at_pos[0] = !le[0];
        for (int i = 1; i < MAX_SLOTS; i++) begin
            at_pos[i] = !le[i] && le[i-1];
        end
        for (int i = 0; i < MAX_SLOTS; i++) begin
            late[i] = (CntW'(i) < r_count) && !le[i]
                      && ((DlW + 1)'(i) + (DlW + 1)'(2) > {1'b0, r_cell_dl[i]});
            if (at_pos[i]) begin
                pos = pos | CntW'(i);
            end
        end
        ok = (r_count < CntW'(MAX_SLOTS)) && (DlW'(pos) < r_dl)
             && !(|late);
        n_count  = ok ? r_count + CntW'(1) : r_count;
        sum_wide = {1'b0, r_sum} + (SumW + 1)'(r_profit);
        n_sum    = sum_wide[SumW] ? '1 : sum_wide[SumW-1:0];
    end

    assign list_next          = CntW'(r_list_idx) + CntW'(1);
    assign o_status.more_list = r_last && (n_count != '0);
    assign o_status.list_end  = (list_next == r_count);
    assign o_result           = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            if (i_cmd.load && i_job.first_job) begin
                r_count <= '0;
                r_sum   <= '0;
            end else if (i_cmd.decide && ok) begin
                r_count <= n_count;
                r_sum   <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id     <= i_job.job_id;
            r_dl     <= i_job.deadline;
            r_profit <= i_job.profit;
            r_last   <= i_job.last_job;
        end

        if (i_cmd.decide && ok) begin
            if (at_pos[0]) begin
                r_cell_id[0]     <= r_id;
                r_cell_dl[0]     <= r_dl;
                r_cell_profit[0] <= r_profit;
            end
            for (int i = 1; i < MAX_SLOTS; i++) begin
                if (at_pos[i]) begin
                    r_cell_id[i]     <= r_id;
                    r_cell_dl[i]     <= r_dl;
                    r_cell_profit[i] <= r_profit;
                end else if (!le[i]) begin
                    r_cell_id[i]     <= r_cell_id[i-1];
                    r_cell_dl[i]     <= r_cell_dl[i-1];
                    r_cell_profit[i] <= r_cell_profit[i-1];
                end
            end
        end

        if (i_cmd.decide) begin
            r_list_idx         <= '0;
            r_out.kind         <= KindDecision;
            r_out.accepted     <= ok;
            r_out.slot_index   <= ok ? SlotW'(pos) + SlotW'(1) : '0;
            r_out.job_id_out   <= r_id;
            r_out.profit_out   <= r_profit;
            r_out.total_profit <= ok ? n_sum : r_sum;
            r_out.job_count    <= CountW'(n_count);
            r_out.last_out     <= !r_last || (n_count == '0);
        end else if (i_cmd.list) begin
            r_list_idx         <= r_list_idx + IdxW'(1);
            r_out.kind         <= KindListing;
            r_out.accepted     <= 1'b0;
            r_out.slot_index   <= SlotW'(list_next);
            r_out.job_id_out   <= r_cell_id[r_list_idx];
            r_out.profit_out   <= r_cell_profit[r_list_idx];
            r_out.total_profit <= r_sum;
            r_out.job_count    <= CountW'(r_count);
            r_out.last_out     <= (list_next == r_count);
        end
    end

endmodule

>>> design/deadline_job_sequencer_top.sv
// channel   dir  type           transaction
// i_job     in   djs_job_if     one offered job (id, deadline, profit, first, last)
// o_result  out  djs_result_if  one decision or one schedule listing entry
//
// a job is captured in idle, then evaluated against all slot cells at once;
// the row is shifted and the decision is loaded into the output register
// a last job with a nonempty schedule then lists each scheduled entry in order
// synchronous active-low reset empties the schedule and clears the total
// a stalled output holds its result; evaluation and listing wait for it
module deadline_job_sequencer_top import djs_pkg::*; #(
    parameter int MAX_SLOTS = DefaultMaxSlots
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    djs_job_if.sink       i_job,
    djs_result_if.source  o_result
);

    t_cmd    cmd;
    t_status status;

    djs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_job.valid),
        .o_in_ready  (i_job.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    djs_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_job    (i_job.data),
        .o_status (status),
        .o_result (o_result.data)
    );

endmodule

>>> verif/deadline_job_sequencer_top_tb.sv
module deadline_job_sequencer_top_tb import djs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxSlots  = DefaultMaxSlots;
    localparam int SumMax    = (1 << SumW) - 1;
    localparam int JobTarget = 230;

    logic i_clk = 1'b0;
    logic i_rst_n;

    djs_job_if    job_if ();
    djs_result_if res_if ();

    deadline_job_sequencer_top #(
        .MAX_SLOTS (MaxSlots)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (job_if),
        .o_result (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // schedule mirror, sorted by deadline
    logic [IdW-1:0]     sched_id     [MaxSlots];
    logic [DlW-1:0]     sched_dl     [MaxSlots];
    logic [ProfitW-1:0] sched_profit [MaxSlots];
    int unsigned        sched_count  = 0;
    int unsigned        profit_total = 0;

    t_result awaited_results [$];
    int      jobs_offered = 0;
    int      mismatches   = 0;
    bit      gaps_on      = 1'b0;
    bit      stalls_on    = 1'b0;

    function automatic void add_awaited(input t_result r);
        awaited_results = {awaited_results, r};
    endfunction

    function automatic void sequence_job(input t_job j);
        int unsigned n;
        int unsigned pos;
        int unsigned slot;
        int unsigned s;
        bit          ok;
        t_result     r;
        if (j.first_job) begin
            sched_count  = 0;
            profit_total = 0;
        end
        n    = sched_count;
        pos  = 0;
        slot = 0;
        while (pos < n && sched_dl[pos] <= j.deadline) pos++;
        ok = (n < MaxSlots) && (pos + 1 <= j.deadline);
        for (int i = 0; ok && i < n; i++) begin
            s = (i < pos) ? i + 1 : i + 2;
            if (s > sched_dl[i]) ok = 1'b0;
        end
        if (ok) begin
            for (int i = n; i > pos; i--) begin
                sched_id[i]     = sched_id[i-1];
                sched_dl[i]     = sched_dl[i-1];
                sched_profit[i] = sched_profit[i-1];
            end
            sched_id[pos]     = j.job_id;
            sched_dl[pos]     = j.deadline;
            sched_profit[pos] = j.profit;
            n++;
            sched_count  = n;
            profit_total = profit_total + j.profit;
            if (profit_total > SumMax) profit_total = SumMax;
            slot = pos + 1;
        end
        r.kind         = KindDecision;
        r.accepted     = ok;
        r.slot_index   = SlotW'(slot);
        r.job_id_out   = j.job_id;
        r.profit_out   = j.profit;
        r.total_profit = SumW'(profit_total);
        r.job_count    = CountW'(sched_count);
        r.last_out     = !j.last_job || n == 0;
        add_awaited(r);
        if (j.last_job) begin
            for (int i = 0; i < n; i++) begin
                r.kind       = KindListing;
                r.accepted   = 1'b0;
                r.slot_index = SlotW'(i + 1);
                r.job_id_out = sched_id[i];
                r.profit_out = sched_profit[i];
                r.last_out   = (i + 1 == n);
                add_awaited(r);
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic offer_job(input logic [IdW-1:0] id, input logic [DlW-1:0] dl,
                             input logic [ProfitW-1:0] profit, input bit first,
                             input bit last);
        int   gap;
        t_job j;
        gap = pick_gap();
        j = '{job_id: id, deadline: dl, profit: profit, first_job: first, last_job: last};
        if (gap > 0) begin
            job_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        job_if.valid <= 1'b1;
        job_if.data  <= j;
        do @(posedge i_clk); while (!job_if.ready);
        sequence_job(j);
        jobs_offered++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected transaction: kind %0d job_id_out %0d",
                       res_if.data.kind, res_if.data.job_id_out);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(res_if.data.kind));
                check_field("accepted", 32'(want.accepted), 32'(res_if.data.accepted));
                check_field("slot_index", 32'(want.slot_index),
                            32'(res_if.data.slot_index));
                check_field("job_id_out", 32'(want.job_id_out),
                            32'(res_if.data.job_id_out));
                check_field("profit_out", 32'(want.profit_out),
                            32'(res_if.data.profit_out));
                check_field("total_profit", 32'(want.total_profit),
                            32'(res_if.data.total_profit));
                check_field("job_count", 32'(want.job_count),
                            32'(res_if.data.job_count));
                check_field("last_out", 32'(want.last_out), 32'(res_if.data.last_out));
            end
        end
    end

    // result backpressure
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!stalls_on) begin
                res_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    res_if.ready <= 1'b1;
                end else if (r < 95) begin
                    res_if.ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else begin
                    res_if.ready <= 1'b0;
                    stall_left = $urandom_range(10, 30);
                end
            end
        end
    end

    task automatic test_field_extremes();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        offer_job(10'd0, 6'd63, 16'hFFFF, 1'b1, 1'b0);
        offer_job(10'd1023, 6'd1, 16'hFFFF, 1'b0, 1'b0);
        offer_job(10'h155, 6'd2, 16'h8000, 1'b0, 1'b0);
        offer_job(10'h2AA, 6'd2, 16'h7FFF, 1'b0, 1'b0);
        offer_job(10'h3FF, 6'd63, 16'h0000, 1'b0, 1'b1);
    endtask

    task automatic test_zero_deadline();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        // empty schedule when the listing is requested
        offer_job(10'h123, 6'd0, 16'hABCD, 1'b1, 1'b1);
        offer_job(10'h0F0, 6'd0, 16'h1234, 1'b1, 1'b0);
        offer_job(10'h00F, 6'd1, 16'h1000, 1'b0, 1'b1);
    endtask

    task automatic test_first_and_last();
        offer_job(10'h3C3, 6'd5, 16'hFFFF, 1'b1, 1'b1);
        offer_job(10'h000, 6'd1, 16'h0000, 1'b1, 1'b1);
    endtask

    task automatic test_equal_deadlines();
        offer_job(10'h101, 6'd3, 16'h9000, 1'b1, 1'b0);
        offer_job(10'h102, 6'd3, 16'h9000, 1'b0, 1'b0);
        offer_job(10'h103, 6'd3, 16'h8000, 1'b0, 1'b0);
        offer_job(10'h104, 6'd3, 16'h7000, 1'b0, 1'b1);
    endtask

    task automatic test_infeasible_shift();
        // an earlier deadline that pushes a listed job past its own deadline
        offer_job(10'h211, 6'd2, 16'h5000, 1'b1, 1'b0);
        offer_job(10'h212, 6'd2, 16'h4000, 1'b0, 1'b0);
        offer_job(10'h213, 6'd1, 16'h3000, 1'b0, 1'b1);
    endtask

    task automatic test_schedule_full();
        logic [ProfitW-1:0] profit;
        profit    = 16'hFFFF;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        for (int i = 0; i < MaxSlots + 2; i++) begin
            offer_job(IdW'($urandom_range(0, 1023)),
                      (i < MaxSlots) ? DlW'($urandom_range(MaxSlots, 63)) : 6'd63,
                      profit, i == 0, i == MaxSlots + 1);
            profit = profit - ProfitW'($urandom_range(0, 1500));
        end
    endtask

    task automatic test_random_sequences();
        int          len;
        int          r;
        int unsigned profit;
        int unsigned step;
        logic [DlW-1:0] dl;
        while (jobs_offered < JobTarget) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 15) begin
                offer_job(IdW'($urandom_range(0, 1023)), DlW'($urandom_range(0, 63)),
                          ProfitW'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else begin
                len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12);
                profit = $urandom_range(0, 65535);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 5)       dl = 6'd0;
                    else if (r < 15) dl = DlW'($urandom_range(32, 63));
                    else             dl = DlW'($urandom_range(1, (len + 2 > 63) ? 63 : len + 2));
                    offer_job(IdW'($urandom_range(0, 1023)), dl, ProfitW'(profit),
                              i == 0, i == len - 1);
                    step   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3000);
                    profit = (profit > step) ? profit - step : 0;
                end
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        job_if.valid <= 1'b0;
        job_if.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_zero_deadline();
        test_first_and_last();
        test_equal_deadlines();
        test_infeasible_shift();
        test_schedule_full();
        test_random_sequences();

        job_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
